// File: rtl/assert_macros.svh
// shared assertion helpers, sampled on clock, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define AST_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define AST_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/abkf_pkg.sv
package abkf_pkg;

   localparam int WORD_W = 48;
   localparam int FRAC_W = 32;
   localparam int HALF_W = WORD_W / 2;
   localparam int ACC_W  = 2 * WORD_W;
   localparam int NUM_W  = WORD_W + FRAC_W;
   localparam int CNT_W  = 7;

   // micro-op codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // operand / destination codes
   localparam logic [4:0] S_ZERO = 5'd0;
   localparam logic [4:0] S_G    = 5'd1;
   localparam logic [4:0] S_M    = 5'd2;
   localparam logic [4:0] S_DT   = 5'd3;
   localparam logic [4:0] S_R    = 5'd4;
   localparam logic [4:0] S_QA   = 5'd5;
   localparam logic [4:0] S_QG   = 5'd6;
   localparam logic [4:0] S_ANG  = 5'd7;
   localparam logic [4:0] S_BIAS = 5'd8;
   localparam logic [4:0] S_P0   = 5'd9;
   localparam logic [4:0] S_P1   = 5'd10;
   localparam logic [4:0] S_P2   = 5'd11;
   localparam logic [4:0] S_P3   = 5'd12;
   localparam logic [4:0] S_T0   = 5'd13;
   localparam logic [4:0] S_T1   = 5'd14;
   localparam logic [4:0] S_ERR  = 5'd15;
   localparam logic [4:0] S_E    = 5'd16;
   localparam logic [4:0] S_K0   = 5'd17;
   localparam logic [4:0] S_K1   = 5'd18;

   localparam logic [4:0] UC_LAST = 5'd29;

   // csr register indexes
   localparam logic [1:0] REG_R  = 2'd0;
   localparam logic [1:0] REG_QA = 2'd1;
   localparam logic [1:0] REG_QG = 2'd2;
   localparam logic [1:0] REG_DT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic [4:0] dst;
   } uop_type;

   function automatic uop_type mk(input logic [1:0] op, input logic [4:0] a,
                                  input logic [4:0] b, input logic [4:0] d);
      uop_type u;
      u.op = op;
      u.src_a = a;
      u.src_b = b;
      u.dst = d;
      return u;
   endfunction

   // predict then update, one op per entry
   function automatic uop_type ucode(input logic [4:0] pc);
      uop_type u;
      case (pc)
         5'd0:  u = mk(OP_SUB, S_G,    S_BIAS, S_T0);   // rate
         5'd1:  u = mk(OP_MUL, S_T0,   S_DT,   S_T0);
         5'd2:  u = mk(OP_ADD, S_ANG,  S_T0,   S_ANG);
         5'd3:  u = mk(OP_SUB, S_QA,   S_P1,   S_T0);
         5'd4:  u = mk(OP_SUB, S_T0,   S_P2,   S_T0);   // d00
         5'd5:  u = mk(OP_SUB, S_ZERO, S_P3,   S_T1);   // d01
         5'd6:  u = mk(OP_MUL, S_T0,   S_DT,   S_T0);
         5'd7:  u = mk(OP_ADD, S_P0,   S_T0,   S_P0);
         5'd8:  u = mk(OP_MUL, S_T1,   S_DT,   S_T0);
         5'd9:  u = mk(OP_ADD, S_P1,   S_T0,   S_P1);
         5'd10: u = mk(OP_ADD, S_P2,   S_T0,   S_P2);
         5'd11: u = mk(OP_MUL, S_QG,   S_DT,   S_T0);
         5'd12: u = mk(OP_ADD, S_P3,   S_T0,   S_P3);
         5'd13: u = mk(OP_SUB, S_M,    S_ANG,  S_ERR);
         5'd14: u = mk(OP_ADD, S_R,    S_P0,   S_E);
         5'd15: u = mk(OP_DIV, S_P0,   S_E,    S_K0);
         5'd16: u = mk(OP_DIV, S_P2,   S_E,    S_K1);
         5'd17: u = mk(OP_MUL, S_K1,   S_P0,   S_T0);
         5'd18: u = mk(OP_MUL, S_K1,   S_P1,   S_T1);
         5'd19: u = mk(OP_SUB, S_P2,   S_T0,   S_P2);
         5'd20: u = mk(OP_SUB, S_P3,   S_T1,   S_P3);
         5'd21: u = mk(OP_MUL, S_K0,   S_P0,   S_T0);
         5'd22: u = mk(OP_MUL, S_K0,   S_P1,   S_T1);
         5'd23: u = mk(OP_SUB, S_P0,   S_T0,   S_P0);
         5'd24: u = mk(OP_SUB, S_P1,   S_T1,   S_P1);
         5'd25: u = mk(OP_MUL, S_K0,   S_ERR,  S_T0);
         5'd26: u = mk(OP_ADD, S_ANG,  S_T0,   S_ANG);
         5'd27: u = mk(OP_MUL, S_K1,   S_ERR,  S_T0);
         5'd28: u = mk(OP_ADD, S_BIAS, S_T0,   S_BIAS);
         default: u = mk(OP_ADD, S_ZERO, S_ZERO, S_ZERO);
      endcase
      return u;
   endfunction

   function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] x);
      return x[WORD_W-1] ? (~x + 1'b1) : x;
   endfunction

   // saturating signed add, sub selects a - b
   function automatic logic [WORD_W-1:0] add_sat(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic sub);
      logic [WORD_W:0] s;
      logic [WORD_W-1:0] wmax;
      s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b})
              : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
      wmax = {1'b0, {(WORD_W-1){1'b1}}};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? ~wmax : wmax;
      end
      return s[WORD_W-1:0];
   endfunction

endpackage

// File: rtl/angle_bias_kalman_filter.sv
// angle / gyro-bias kalman filter, two states, signed 48 bit fixed point (32 fraction bits)
// req channel: one word carries gyro_rate and measured_angle; taken when req_valid is high
//   and req_stall is low. req_stall stays high while a word is being filtered
// rsp channel: one word per request, fused_angle and bias_estimate after the update step
// csr: apb-style, 64 bit data, register i at byte address 8*i (r, q_angle, q_bias, dt);
//   writes only while idle (user's duty, not enforced by the block); pready is always high
// processing: a 30-entry microcode sequence runs on one shared datapath
//   add/sub in a single step, multiply in four 24x24 partial products plus rounding,
//   gain divide by restoring division, one quotient bit per cycle over 80 bits
//   17 add/sub + 10 mul + 2 div steps, one closing step, then the done state hands out
// a new word is taken only in idle, after the previous result has left the done state
// the output register parts the two sides: a new request is taken while the previous
//   result still waits; a finished result waits in done while the previous one is stalled
// rsp payload stays fixed while rsp_valid and rsp_stall are both high
// reset: estimates cleared, covariance set to identity, csr registers to defaults
module angle_bias_kalman_filter
   import abkf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [WORD_W-1:0] req_gyro_rate,
   input  logic signed [WORD_W-1:0] req_measured_angle,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_fused_angle,
   output logic signed [WORD_W-1:0] rsp_bias_estimate,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [4:0]               csr_paddr,
   input  logic [63:0]              csr_pwdata,
   output logic [63:0]              csr_prdata,
   output logic                     csr_pready
);
`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W + 1);
   localparam logic [WORD_W-1:0] ONE_FX = WORD_W'(1) << FRAC_W;

   // csr registers
   logic [46:0] r_ff, qa_ff, qg_ff;
   logic [31:0] dt_ff;

   // filter state and scratch
   logic [WORD_W-1:0] ang_ff, bias_ff, p0_ff, p1_ff, p2_ff, p3_ff;
   logic [WORD_W-1:0] t0_ff, t1_ff, err_ff, e_ff, k0_ff, k1_ff, g_ff, m_ff;
   logic [WORD_W-1:0] ang_in, bias_in, p0_in, p1_in, p2_in, p3_in;
   logic [WORD_W-1:0] t0_in, t1_in, err_in, e_in, k0_in, k1_in;

   // sequencer
   logic [1:0]       state_ff, state_in;
   logic [4:0]       pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // multiplier / divider working registers
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [NUM_W-1:0]  num_ff, num_in, q_ff, q_in;
   logic [WORD_W:0]   rem_ff, rem_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] out_ang_ff, out_bias_ff;

   uop_type           uop;
   logic [WORD_W-1:0] opa, opb, ma, mb, res;
   logic              neg, wr_en, req_take, rsp_free;
   logic [HALF_W-1:0] ha, hb;
   logic [WORD_W-1:0] pp;
   logic [ACC_W-1:0]  pp_sh, rnd;
   logic [63:0]       mres, mlim;
   logic [NUM_W-1:0]  qlim, qsat;
   logic [WORD_W:0]   rtry;
   logic [WORD_W-1:0] mval;

   function automatic logic [WORD_W-1:0] pick(input logic [4:0] s,
      input logic [WORD_W-1:0] g, m, dt, r, qa, qg, an, bi, p0, p1, p2, p3,
      input logic [WORD_W-1:0] t0, t1, er, e, k0, k1);
      logic [WORD_W-1:0] v;
      case (s)
         S_G:    v = g;
         S_M:    v = m;
         S_DT:   v = dt;
         S_R:    v = r;
         S_QA:   v = qa;
         S_QG:   v = qg;
         S_ANG:  v = an;
         S_BIAS: v = bi;
         S_P0:   v = p0;
         S_P1:   v = p1;
         S_P2:   v = p2;
         S_P3:   v = p3;
         S_T0:   v = t0;
         S_T1:   v = t1;
         S_ERR:  v = er;
         S_E:    v = e;
         S_K0:   v = k0;
         S_K1:   v = k1;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fused_angle   = out_ang_ff;
   assign rsp_bias_estimate = out_bias_ff;
   assign csr_pready = 1'b1;

   // csr read mux
   always_comb begin
      unique case (csr_paddr[4:3])
         REG_R:   csr_prdata = {17'd0, r_ff};
         REG_QA:  csr_prdata = {17'd0, qa_ff};
         REG_QG:  csr_prdata = {17'd0, qg_ff};
         REG_DT:  csr_prdata = {32'd0, dt_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff  <= 47'd2147483648;
         qa_ff <= 47'd429497;
         qg_ff <= 47'd1288490;
         dt_ff <= 32'd4294967;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[4:3])
            REG_R:   r_ff  <= csr_pwdata[46:0];
            REG_QA:  qa_ff <= csr_pwdata[46:0];
            REG_QG:  qg_ff <= csr_pwdata[46:0];
            default: dt_ff <= csr_pwdata[31:0];
         endcase
      end
   end

   // operand fetch
   always_comb begin
      uop = ucode(pc_ff);
      opa = pick(uop.src_a, g_ff, m_ff, {16'd0, dt_ff}, {1'b0, r_ff}, {1'b0, qa_ff},
                 {1'b0, qg_ff}, ang_ff, bias_ff, p0_ff, p1_ff, p2_ff, p3_ff,
                 t0_ff, t1_ff, err_ff, e_ff, k0_ff, k1_ff);
      opb = pick(uop.src_b, g_ff, m_ff, {16'd0, dt_ff}, {1'b0, r_ff}, {1'b0, qa_ff},
                 {1'b0, qg_ff}, ang_ff, bias_ff, p0_ff, p1_ff, p2_ff, p3_ff,
                 t0_ff, t1_ff, err_ff, e_ff, k0_ff, k1_ff);
      ma  = mag(opa);
      mb  = mag(opb);
      neg = opa[WORD_W-1] ^ opb[WORD_W-1];
   end

   // shared datapath: partial product, rounding, divider step, saturation
   always_comb begin
      ha = cnt_ff[1] ? ma[WORD_W-1:HALF_W] : ma[HALF_W-1:0];
      hb = cnt_ff[0] ? mb[WORD_W-1:HALF_W] : mb[HALF_W-1:0];
      pp = WORD_W'(ha) * WORD_W'(hb);
      case (cnt_ff[1:0])
         2'd0:    pp_sh = ACC_W'(pp);
         2'd3:    pp_sh = ACC_W'(pp) << WORD_W;
         default: pp_sh = ACC_W'(pp) << HALF_W;
      endcase
      rnd  = acc_ff + (ACC_W'(1) << (FRAC_W - 1));
      mres = rnd[FRAC_W +: 64];
      mlim = neg ? (64'd1 << (WORD_W - 1)) : ((64'd1 << (WORD_W - 1)) - 64'd1);
      mval = (mres > mlim) ? mlim[WORD_W-1:0] : mres[WORD_W-1:0];

      qlim = neg ? (NUM_W'(1) << (WORD_W - 1)) : ((NUM_W'(1) << (WORD_W - 1)) - NUM_W'(1));
      qsat = (q_ff > qlim) ? qlim : q_ff;
      rtry = {rem_ff[WORD_W-1:0], num_ff[NUM_W-1]};

      wr_en = 1'b0;
      res   = '0;
      unique case (uop.op)
         OP_ADD: begin
            wr_en = 1'b1;
            res   = add_sat(opa, opb, 1'b0);
         end
         OP_SUB: begin
            wr_en = 1'b1;
            res   = add_sat(opa, opb, 1'b1);
         end
         OP_MUL: begin
            wr_en = (cnt_ff == MUL_LAST);
            res   = neg ? (~mval + 1'b1) : mval;
         end
         default: begin
            wr_en = (cnt_ff == DIV_LAST);
            if (opb == '0) begin
               res = '0;
            end else begin
               res = neg ? (~qsat[WORD_W-1:0] + 1'b1) : qsat[WORD_W-1:0];
            end
         end
      endcase
      if (state_ff != ST_RUN) begin
         wr_en = 1'b0;
      end
   end

   // sequencer and working registers
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               pc_in    = '0;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (wr_en) begin
               cnt_in = '0;
               if (pc_ff == UC_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  pc_in = pc_ff + 5'd1;
               end
            end else if (uop.op == OP_MUL) begin
               acc_in = ((cnt_ff == '0) ? '0 : acc_ff) + pp_sh;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == '0) begin
                  num_in = {ma, FRAC_W'(0)};
                  q_in   = '0;
                  rem_in = '0;
               end else begin
                  num_in = num_ff << 1;
                  if (rtry >= {1'b0, mb}) begin
                     rem_in = rtry - {1'b0, mb};
                     q_in   = {q_ff[NUM_W-2:0], 1'b1};
                  end else begin
                     rem_in = rtry;
                     q_in   = {q_ff[NUM_W-2:0], 1'b0};
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // register write-back
   always_comb begin
      ang_in  = ang_ff;
      bias_in = bias_ff;
      p0_in   = p0_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      p3_in   = p3_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      err_in  = err_ff;
      e_in    = e_ff;
      k0_in   = k0_ff;
      k1_in   = k1_ff;
      if (wr_en) begin
         case (uop.dst)
            S_ANG:   ang_in  = res;
            S_BIAS:  bias_in = res;
            S_P0:    p0_in   = res;
            S_P1:    p1_in   = res;
            S_P2:    p2_in   = res;
            S_P3:    p3_in   = res;
            S_T0:    t0_in   = res;
            S_T1:    t1_in   = res;
            S_ERR:   err_in  = res;
            S_E:     e_in    = res;
            S_K0:    k0_in   = res;
            S_K1:    k1_in   = res;
            default: t0_in   = t0_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ang_ff       <= '0;
         bias_ff      <= '0;
         p0_ff        <= ONE_FX;
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= ONE_FX;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ang_ff       <= ang_in;
         bias_ff      <= bias_in;
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         p3_ff        <= p3_in;
      end
   end

   // payload and scratch, no reset
   always_ff @(posedge clock) begin
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      err_ff <= err_in;
      e_ff   <= e_in;
      k0_ff  <= k0_in;
      k1_ff  <= k1_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (req_take) begin
         g_ff <= req_gyro_rate;
         m_ff <= req_measured_angle;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         out_ang_ff  <= ang_ff;
         out_bias_ff <= bias_ff;
      end
   end

   `AST_NEXT(a_take_runs, req_take, state_ff == ST_RUN, "accepted word did not start")
   `AST_NEXT(a_done_shows, state_ff == ST_DONE && rsp_free, rsp_valid_ff && state_ff == ST_IDLE, "finished word not shown")
   `AST_ALWAYS(a_cnt_bound, cnt_ff <= DIV_LAST, "sub-step counter out of range")
   `AST_ALWAYS(a_pc_bound, pc_ff <= UC_LAST, "microcode address out of range")
   `AST_ALWAYS(a_idle_pc, state_ff != ST_RUN || uop.op == OP_DIV || cnt_ff <= MUL_LAST, "add or mul step overran")

endmodule
